>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the page walker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/pgw_pkg.sv
// ----------------------------------------------------------------------------
// Page walker package
// Shared types, field widths and entry-format constants for the walker.
// ----------------------------------------------------------------------------
package pgw_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MEM_WORDS       = 65536;
   localparam int DEF_MAX_RANGE_BYTES = 4194304;

   // field widths
   localparam int ADDR_W  = 32;
   localparam int WORD_W  = 32;
   localparam int RANGE_W = 23;
   localparam int WIDX_W  = 16;
   // running length may overshoot the request by up to one page
   localparam int LEN_W   = RANGE_W + 1;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 88;

   // entry format
   localparam int PAGE_SHIFT  = 12;
   localparam int BIG_SHIFT   = 22;
   localparam int PAGE_BYTES  = 4096;
   localparam int BIT_PRESENT = 0;
   localparam int BIT_BIG     = 7;

   // front-to-back queue
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int CNT_W   = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_RANGE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [ADDR_W-1:0]    virtual_address;
      logic [RANGE_W-1:0]   req_len;        // already clamped to 1..max
      logic [WIDX_W-1:0]    word_index;
      logic [WORD_W-1:0]    word_data;
   } item_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

>>> rtl/core/pgw_front.sv
// ----------------------------------------------------------------------------
// Page walker front end
// Takes request beats, drops the unused opcode, clamps the range length and
// queues work items for the walker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pgw_front #(
   parameter int MAX_RANGE_BYTES = pgw_pkg::DEF_MAX_RANGE_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pgw_pkg::op_type                 req_op,
   input  logic [pgw_pkg::ADDR_W-1:0]      req_virtual_address,
   input  logic [pgw_pkg::RANGE_W-1:0]     req_range_bytes,
   input  logic [pgw_pkg::WIDX_W-1:0]      req_word_index,
   input  logic [pgw_pkg::WORD_W-1:0]      req_word_data,
   input  pgw_pkg::back_status_type        status,
   output logic                            q_valid,
   output pgw_pkg::item_type               q_item
);
   import pgw_pkg::*;

   item_type               queue_ff [Q_DEPTH];
   logic [Q_AW-1:0]        head_ff, head_in;
   logic [Q_AW-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push;
   logic [RANGE_W-1:0]     len_clamped;
   item_type               new_item;

   // zero means one byte; saturate at the configured maximum
   always_comb begin
      if (req_range_bytes == '0) begin
         len_clamped = RANGE_W'(1);
      end else if (ADDR_W'(req_range_bytes) > ADDR_W'(MAX_RANGE_BYTES)) begin
         len_clamped = RANGE_W'(MAX_RANGE_BYTES);
      end else begin
         len_clamped = req_range_bytes;
      end
   end

   always_comb begin
      new_item.op              = req_op;
      new_item.virtual_address = req_virtual_address;
      new_item.req_len         = len_clamped;
      new_item.word_index      = req_word_index;
      new_item.word_data       = req_word_data;
   end

   assign req_ready = !status.clearing && (count_ff < CNT_W'(Q_DEPTH));
   assign push      = req_valid && req_ready && (req_op != OP_NONE);
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[head_ff];

   always_comb begin
      head_in  = status.pop ? head_ff + Q_AW'(1) : head_ff;
      tail_in  = push ? tail_ff + Q_AW'(1) : tail_ff;
      count_in = count_ff;
      case ({push, status.pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= new_item;
      end
   end

   `ASSERT_IMPLY(a_pop_nonempty, clock, reset, status.pop, count_ff != '0)
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(Q_DEPTH))

endmodule

>>> rtl/core/pgw_back.sv
// ----------------------------------------------------------------------------
// Page walker back end
// Owns the page-table memory, its clearing pass, the directory base
// register, the two-level walk sequencer and the response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pgw_back #(
   parameter int MEM_WORDS = pgw_pkg::DEF_MEM_WORDS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pgw_pkg::ADDR_W-1:0]      csr_wr_data,
   input  logic                            q_valid,
   input  pgw_pkg::item_type               q_item,
   output pgw_pkg::back_status_type        status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_status,
   output logic [pgw_pkg::ADDR_W-1:0]      rsp_physical_address,
   output logic [pgw_pkg::WORD_W-1:0]      rsp_entry_word,
   output logic [pgw_pkg::RANGE_W-1:0]     rsp_contiguous_bytes
);
   import pgw_pkg::*;

   // MEM_WORDS is a power of two; word addresses wrap on the low bits
   localparam int AW = $clog2(MEM_WORDS);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ISSUE = 5'b00100,
      ST_DIR   = 5'b01000,
      ST_TBL   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [ADDR_W-1:0]      dir_base_ff, dir_base_in;

   logic [WORD_W-1:0]      mem [MEM_WORDS];
   logic [WORD_W-1:0]      rd_data_ff;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic                   wr_en;
   logic [WORD_W-1:0]      wr_data;

   // walk context
   logic                   range_ff, range_in;
   logic                   first_ff, first_in;
   logic [ADDR_W-1:0]      cur_ff, cur_in;
   logic [ADDR_W-1:0]      next_ff, next_in;
   logic [ADDR_W-1:0]      phys_ff, phys_in;
   logic [WORD_W-1:0]      entry_ff, entry_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [RANGE_W-1:0]     req_ff, req_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]      rsp_phys_ff, rsp_phys_in;
   logic [WORD_W-1:0]      rsp_entry_ff, rsp_entry_in;
   logic [RANGE_W-1:0]     rsp_len_ff, rsp_len_in;

   logic [ADDR_W-3:0]      dir_word, tbl_word;
   logic                   pg_end, pg_ok;
   logic [ADDR_W-1:0]      pg_phys;
   logic [LEN_W-1:0]       step, len_sum;
   logic [ADDR_W-1:0]      cur_sum, next_sum;
   logic                   cand_ok, more, fin, pop;

   // entry word addresses: fields concatenate, no carry
   assign dir_word = {dir_base_ff[ADDR_W-1:PAGE_SHIFT], cur_ff[ADDR_W-1:BIG_SHIFT]};
   assign tbl_word = {rd_data_ff[ADDR_W-1:PAGE_SHIFT], cur_ff[BIG_SHIFT-1:PAGE_SHIFT]};
   assign rd_addr  = (state_ff == ST_ISSUE) ? dir_word[AW-1:0] : tbl_word[AW-1:0];

   // outcome of the page in flight
   always_comb begin
      pg_ok   = rd_data_ff[BIT_PRESENT];
      pg_end  = 1'b0;
      pg_phys = {rd_data_ff[ADDR_W-1:PAGE_SHIFT], cur_ff[PAGE_SHIFT-1:0]};
      case (state_ff)
         ST_DIR: begin
            pg_end  = !rd_data_ff[BIT_PRESENT] || rd_data_ff[BIT_BIG];
            pg_phys = {rd_data_ff[ADDR_W-1:BIG_SHIFT], cur_ff[BIG_SHIFT-1:0]};
         end
         ST_TBL: begin
            pg_end = 1'b1;
         end
         default: begin
            pg_end = 1'b0;
         end
      endcase
   end

   // first page covers up to its end, later pages a whole page each
   assign step     = first_ff ? LEN_W'(PAGE_BYTES) - LEN_W'(cur_ff[PAGE_SHIFT-1:0])
                              : LEN_W'(PAGE_BYTES);
   assign len_sum  = (first_ff ? '0 : len_ff) + step;
   assign cur_sum  = cur_ff + ADDR_W'(step);
   assign next_sum = (first_ff ? pg_phys : next_ff) + ADDR_W'(step);
   assign cand_ok  = pg_ok && (first_ff || (pg_phys == next_ff));
   assign more     = len_sum < LEN_W'(req_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      dir_base_in   = csr_wr_en ? csr_wr_data : dir_base_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = '0;
      pop           = 1'b0;
      fin           = 1'b0;
      range_in      = range_ff;
      first_in      = first_ff;
      cur_in        = cur_ff;
      next_in       = next_ff;
      phys_in       = phys_ff;
      entry_in      = entry_ff;
      len_in        = len_ff;
      req_in        = req_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_phys_in   = rsp_phys_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_len_in    = rsp_len_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OP_WRITE) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(q_item.word_index);
                  wr_data = q_item.word_data;
                  pop     = 1'b1;
               end else if (!rsp_valid_ff || rsp_ready) begin
                  pop      = 1'b1;
                  range_in = (q_item.op == OP_RANGE);
                  first_in = 1'b1;
                  cur_in   = q_item.virtual_address;
                  req_in   = q_item.req_len;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_DIR;
         end
         ST_DIR, ST_TBL: begin
            if (!pg_end) begin
               state_in = ST_TBL;
            end else begin
               if (first_ff) begin
                  phys_in  = pg_phys;
                  entry_in = rd_data_ff;
               end
               if (first_ff && !pg_ok) begin
                  // fault on the first page
                  fin           = 1'b1;
                  rsp_status_in = 1'b1;
                  rsp_phys_in   = '0;
                  rsp_entry_in  = '0;
                  rsp_len_in    = '0;
               end else if (first_ff && !range_ff) begin
                  fin           = 1'b1;
                  rsp_status_in = 1'b0;
                  rsp_phys_in   = pg_phys;
                  rsp_entry_in  = rd_data_ff;
                  rsp_len_in    = '0;
               end else if (cand_ok && more) begin
                  first_in = 1'b0;
                  len_in   = len_sum;
                  cur_in   = cur_sum;
                  next_in  = next_sum;
                  state_in = ST_ISSUE;
               end else begin
                  // run ends: request met, or next page absent or not adjacent
                  fin           = 1'b1;
                  rsp_status_in = 1'b0;
                  rsp_phys_in   = first_ff ? pg_phys : phys_ff;
                  rsp_entry_in  = first_ff ? rd_data_ff : entry_ff;
                  rsp_len_in    = cand_ok ? req_ff : len_ff[RANGE_W-1:0];
               end
            end
            if (fin) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         dir_base_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         dir_base_ff  <= dir_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      range_ff      <= range_in;
      first_ff      <= first_in;
      cur_ff        <= cur_in;
      next_ff       <= next_in;
      phys_ff       <= phys_in;
      entry_ff      <= entry_in;
      len_ff        <= len_in;
      req_ff        <= req_in;
      rsp_status_ff <= rsp_status_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_len_ff    <= rsp_len_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign status.pop            = pop;
   assign status.clearing       = (state_ff == ST_CLEAR);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_physical_address  = rsp_phys_ff;
   assign rsp_entry_word        = rsp_entry_ff;
   assign rsp_contiguous_bytes  = rsp_len_ff;

   `ASSERT_IMPLY(a_fin_slot_free, clock, reset, fin, !rsp_valid_ff)
   `ASSERT_IMPLY(a_no_rsp_in_clear, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff)
   `ASSERT_IMPLY(a_tbl_after_dir, clock, reset, state_ff == ST_TBL, $past(state_ff == ST_DIR))

endmodule

>>> rtl/core/two_level_page_table_walker.sv
// A lookup reads the directory entry and, for a 4 KB page, then the table entry;
//   a range scan walks each further page the same way until the run ends.
// The walker handles one item at a time: a write is done in the idle state, a lookup
//   waits on the dependent reads of the single memory read port; the queue takes beats.
// Reset: clears control state, then a clearing pass zeroes the table memory
//   word by word with req_tready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// Two-level page table walker
// 32-bit two-level walk (4 KB pages, 4 MB big pages) over a local page-table
// memory, with single and contiguous-range lookups.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_level_page_table_walker #(
   parameter int MEM_WORDS       = pgw_pkg::DEF_MEM_WORDS,
   parameter int MAX_RANGE_BYTES = pgw_pkg::DEF_MAX_RANGE_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,

   // directory base register; low 12 bits ignored
   input  logic                               csr_wr_en,
   input  logic [pgw_pkg::ADDR_W-1:0]         csr_wr_data,

   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata, low bit up: virtual_address[31:0], range_bytes[54:32],
   //   word_index[70:55], word_data[102:71], zero pad [103]
   input  logic [pgw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0]                         req_tuser,

   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata, low bit up: physical_address[31:0], entry_word[63:32],
   //   contiguous_bytes[86:64], zero pad [87]
   output logic [pgw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // tuser: status[0] (1 = page fault)
   output logic [0:0]                         rsp_tuser
);
   import pgw_pkg::*;

   // request beat fields
   op_type               in_op;
   logic [ADDR_W-1:0]    in_va;
   logic [RANGE_W-1:0]   in_range;
   logic [WIDX_W-1:0]    in_widx;
   logic [WORD_W-1:0]    in_wdata;

   // front to back
   logic                 q_valid;
   item_type             q_item;
   back_status_type      back_status;

   // response fields
   logic                 out_status;
   logic [ADDR_W-1:0]    out_phys;
   logic [WORD_W-1:0]    out_entry;
   logic [RANGE_W-1:0]   out_len;

   assign in_op    = op_type'(req_tuser);
   assign in_va    = req_tdata[ADDR_W-1:0];
   assign in_range = req_tdata[ADDR_W+RANGE_W-1:ADDR_W];
   assign in_widx  = req_tdata[ADDR_W+RANGE_W+WIDX_W-1:ADDR_W+RANGE_W];
   assign in_wdata = req_tdata[ADDR_W+RANGE_W+WIDX_W+WORD_W-1:ADDR_W+RANGE_W+WIDX_W];

   // front: accepts beats, drops the unused opcode, queues work in order
   pgw_front #(
      .MAX_RANGE_BYTES (MAX_RANGE_BYTES)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_tvalid),
      .req_ready           (req_tready),
      .req_op              (in_op),
      .req_virtual_address (in_va),
      .req_range_bytes     (in_range),
      .req_word_index      (in_widx),
      .req_word_data       (in_wdata),
      .status              (back_status),
      .q_valid             (q_valid),
      .q_item              (q_item)
   );

   // back: writes and walks strictly in queue order, so a write never
   // overtakes an earlier lookup
   pgw_back #(
      .MEM_WORDS (MEM_WORDS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .status               (back_status),
      .rsp_valid            (rsp_tvalid),
      .rsp_ready            (rsp_tready),
      .rsp_status           (out_status),
      .rsp_physical_address (out_phys),
      .rsp_entry_word       (out_entry),
      .rsp_contiguous_bytes (out_len)
   );

   assign rsp_tdata = {1'b0, out_len, out_entry, out_phys};
   assign rsp_tuser = out_status;

   // a response beat only ever comes from a queued lookup, never from reset
   `ASSERT_IMPLY(a_rsp_needs_item, clock, reset, $rose(rsp_tvalid), $past(!back_status.clearing))

endmodule
